>>> rtl/gda_pkg.sv
package gda_pkg;

	localparam int unsigned YearW  = 14;
	localparam int unsigned MonthW = 4;
	localparam int unsigned DayW   = 5;
	localparam int unsigned CountW = 16;
	localparam int unsigned TotalW = CountW + 1;
	localparam int unsigned CentW  = 7;
	localparam int unsigned RemW   = 7;

	localparam logic [YearW-1:0]  MaxYear   = YearW'(9999);
	localparam logic [YearW-1:0]  MinYear   = YearW'(1);
	localparam logic [MonthW-1:0] January   = MonthW'(1);
	localparam logic [MonthW-1:0] February  = MonthW'(2);
	localparam logic [MonthW-1:0] December  = MonthW'(12);
	localparam logic [DayW-1:0]   LastDay   = DayW'(31);
	localparam logic [RemW-1:0]   LastInCent = RemW'(99);

	// floor(y / 100) ~= (y * RecipHundred) >> RecipShift, off by at most one below
	localparam int unsigned RecipShift   = 19;
	localparam int unsigned ProdW        = YearW + RecipShift - 5;
	localparam logic [12:0] RecipHundred = 13'd5243;

	typedef struct packed {
		logic [YearW-1:0]  start_year;
		logic [MonthW-1:0] start_month;
		logic [DayW-1:0]   start_day;
		logic [CountW-1:0] days_ahead;
	} in_word_t;

	typedef struct packed {
		logic [YearW-1:0]  end_year;
		logic [MonthW-1:0] end_month;
		logic [DayW-1:0]   end_day;
		logic              year_overflow;
	} out_word_t;

	function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
		input logic leap);
		logic [DayW-1:0] len;
		unique case (m)
			February:               len = leap ? DayW'(29) : DayW'(28);
			4'd4, 4'd6, 4'd9, 4'd11: len = DayW'(30);
			default:                len = DayW'(31);
		endcase
		return len;
	endfunction

endpackage

>>> rtl/gda_in_if.sv
interface gda_in_if;
	logic               valid;
	logic               ready;
	gda_pkg::in_word_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/gda_out_if.sv
interface gda_out_if;
	logic               valid;
	logic               ready;
	gda_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/gregorian_date_add_days_core.sv
// channel   dir   word         handshake
// req       in    in_word_t    valid/ready
// rsp       out   out_word_t   valid/ready
//
// An item passes through setup (load, year/100 by reciprocal, remainder fix), then
// walks one month per step and posts the result; the month walk through the shared
// subtract/compare unit sets how long an item takes.
// arst_n clears the sequencer and the result valid flag.
// A new item is taken whenever the sequencer is idle, even while a result waits;
// the finished result holds in its state until the result register is free.
module gregorian_date_add_days_core (
	input  logic      clk,
	input  logic      arst_n,
	gda_in_if.sink    req,
	gda_out_if.source rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_FIX,
		S_WALK
	} state_t;

	state_t                           state_q;
	logic [gda_pkg::YearW-1:0]        year_q;
	logic [gda_pkg::MonthW-1:0]       month_q;
	logic [gda_pkg::TotalW-1:0]       total_q;
	logic [gda_pkg::CentW-1:0]        cent_q;
	logic [gda_pkg::RemW-1:0]         rem_q;
	logic                             rsp_valid_q;
	gda_pkg::out_word_t               rsp_data_q;

	logic [gda_pkg::ProdW-1:0]        prod;
	logic [gda_pkg::YearW-1:0]        rem_raw;
	logic                             leap;
	logic [gda_pkg::DayW-1:0]         mlen;
	logic                             more;
	logic                             slot_free;
	logic                             walk_end;
	logic [gda_pkg::TotalW-1:0]       start_total;

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.data    = rsp_data_q;
	assign slot_free   = !rsp_valid_q || rsp.ready;

	assign prod        = gda_pkg::ProdW'(year_q) * gda_pkg::ProdW'(gda_pkg::RecipHundred);
	assign rem_raw     = year_q - gda_pkg::YearW'(cent_q) * gda_pkg::YearW'(100);
	assign leap        = (rem_q != '0) ? (year_q[1:0] == 2'b00) : (cent_q[1:0] == 2'b00);
	assign mlen        = gda_pkg::month_days(month_q, leap);
	assign more        = total_q > gda_pkg::TotalW'(mlen);
	assign walk_end    = (state_q == S_WALK) && slot_free && (!more
		|| ((month_q == gda_pkg::December) && (year_q == gda_pkg::MaxYear)));
	assign start_total = ((req.data.start_day == '0) ? gda_pkg::TotalW'(1)
		: gda_pkg::TotalW'(req.data.start_day)) + gda_pkg::TotalW'(req.data.days_ahead);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (walk_end)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						priority if (req.data.start_year == '0)
							year_q <= gda_pkg::MinYear;
						else if (req.data.start_year > gda_pkg::MaxYear)
							year_q <= gda_pkg::MaxYear;
						else
							year_q <= req.data.start_year;
						priority if (req.data.start_month == '0)
							month_q <= gda_pkg::January;
						else if (req.data.start_month > gda_pkg::December)
							month_q <= gda_pkg::December;
						else
							month_q <= req.data.start_month;
						total_q <= start_total;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cent_q  <= prod[gda_pkg::RecipShift +: gda_pkg::CentW];
					state_q <= S_FIX;
				end
				S_FIX: begin
					if (rem_raw >= gda_pkg::YearW'(100)) begin
						rem_q  <= gda_pkg::RemW'(rem_raw - gda_pkg::YearW'(100));
						cent_q <= cent_q + gda_pkg::CentW'(1);
					end else begin
						rem_q <= gda_pkg::RemW'(rem_raw);
					end
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (more) begin
						if (month_q == gda_pkg::December) begin
							if (year_q == gda_pkg::MaxYear) begin
								if (slot_free) begin
									rsp_data_q.end_year      <= gda_pkg::MaxYear;
									rsp_data_q.end_month     <= gda_pkg::December;
									rsp_data_q.end_day       <= gda_pkg::LastDay;
									rsp_data_q.year_overflow <= 1'b1;
									state_q                  <= S_IDLE;
								end
							end else begin
								total_q <= total_q - gda_pkg::TotalW'(mlen);
								month_q <= gda_pkg::January;
								year_q  <= year_q + gda_pkg::YearW'(1);
								if (rem_q == gda_pkg::LastInCent) begin
									rem_q  <= '0;
									cent_q <= cent_q + gda_pkg::CentW'(1);
								end else begin
									rem_q <= rem_q + gda_pkg::RemW'(1);
								end
							end
						end else begin
							total_q <= total_q - gda_pkg::TotalW'(mlen);
							month_q <= month_q + gda_pkg::MonthW'(1);
						end
					end else if (slot_free) begin
						rsp_data_q.end_year      <= year_q;
						rsp_data_q.end_month     <= month_q;
						rsp_data_q.end_day       <= gda_pkg::DayW'(total_q);
						rsp_data_q.year_overflow <= 1'b0;
						state_q                  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned RandWords   = 250;
	localparam int unsigned QuietWords  = 40;
	localparam int unsigned HoldAt      = 100;
	localparam int unsigned HoldLen     = 300;
	localparam int unsigned DrainCycles = 2200;

	typedef struct {
		gda_pkg::in_word_t  stim;
		bit                 typed;
		gda_pkg::out_word_t want;
	} date_row_t;

	logic clk;
	logic arst_n;

	gda_in_if  req_if();
	gda_out_if rsp_if();

	gregorian_date_add_days_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	gda_pkg::out_word_t pending_dates[$];
	int unsigned        mismatch_cnt = 0;
	bit                 quiet_phase  = 1'b0;
	bit                 hold_req     = 1'b0;
	bit                 hold_done    = 1'b0;

	date_row_t date_table[] = '{
		'{'{14'd1,     4'd1,  5'd1,  16'd0},     1'b1, '{14'd1,    4'd1,  5'd1,  1'b0}},
		'{'{14'd0,     4'd0,  5'd0,  16'd0},     1'b1, '{14'd1,    4'd1,  5'd1,  1'b0}},
		'{'{14'd16383, 4'd15, 5'd31, 16'd0},     1'b1, '{14'd9999, 4'd12, 5'd31, 1'b0}},
		'{'{14'd9999,  4'd12, 5'd31, 16'd1},     1'b1, '{14'd9999, 4'd12, 5'd31, 1'b1}},
		'{'{14'd9999,  4'd12, 5'd31, 16'd65535}, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b1}},
		'{'{14'd1,     4'd1,  5'd1,  16'd65535}, 1'b0, '{14'd0,    4'd0,  5'd0,  1'b0}},
		'{'{14'd2000,  4'd2,  5'd28, 16'd1},     1'b1, '{14'd2000, 4'd2,  5'd29, 1'b0}},
		'{'{14'd1900,  4'd2,  5'd28, 16'd1},     1'b1, '{14'd1900, 4'd3,  5'd1,  1'b0}},
		'{'{14'd2024,  4'd2,  5'd28, 16'd1},     1'b1, '{14'd2024, 4'd2,  5'd29, 1'b0}},
		'{'{14'd2023,  4'd2,  5'd31, 16'd0},     1'b1, '{14'd2023, 4'd3,  5'd3,  1'b0}},
		'{'{14'd2024,  4'd2,  5'd31, 16'd0},     1'b1, '{14'd2024, 4'd3,  5'd2,  1'b0}},
		'{'{14'd2023,  4'd12, 5'd31, 16'd1},     1'b1, '{14'd2024, 4'd1,  5'd1,  1'b0}},
		'{'{14'd2100,  4'd2,  5'd29, 16'd0},     1'b1, '{14'd2100, 4'd3,  5'd1,  1'b0}},
		'{'{14'd2023,  4'd4,  5'd31, 16'd0},     1'b1, '{14'd2023, 4'd5,  5'd1,  1'b0}},
		'{'{14'd9999,  4'd1,  5'd1,  16'd364},   1'b1, '{14'd9999, 4'd12, 5'd31, 1'b0}},
		'{'{14'd9999,  4'd1,  5'd1,  16'd365},   1'b1, '{14'd9999, 4'd12, 5'd31, 1'b1}},
		'{'{14'd1,     4'd13, 5'd0,  16'd0},     1'b1, '{14'd1,    4'd12, 5'd1,  1'b0}},
		'{'{14'd400,   4'd2,  5'd29, 16'd0},     1'b1, '{14'd400,  4'd2,  5'd29, 1'b0}},
		'{'{14'd8191,  4'd7,  5'd16, 16'd32767}, 1'b0, '{14'd0,    4'd0,  5'd0,  1'b0}},
		'{'{14'd5461,  4'd10, 5'd10, 16'd43690}, 1'b0, '{14'd0,    4'd0,  5'd0,  1'b0}},
		'{'{14'd10922, 4'd5,  5'd21, 16'd21845}, 1'b0, '{14'd0,    4'd0,  5'd0,  1'b0}},
		'{'{14'd1234,  4'd6,  5'd15, 16'd30000}, 1'b0, '{14'd0,    4'd0,  5'd0,  1'b0}}
	};

	function automatic bit is_leap_year(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_length(int unsigned y, int unsigned m);
		case (m)
			2:          return is_leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:    return 31;
		endcase
	endfunction

	function automatic gda_pkg::out_word_t advance_date(gda_pkg::in_word_t w);
		int unsigned        y;
		int unsigned        m;
		int unsigned        left;
		bit                 ovf;
		gda_pkg::out_word_t r;
		y    = w.start_year;
		m    = w.start_month;
		left = (w.start_day == 0) ? 1 : w.start_day;
		ovf  = 1'b0;
		if (y < 1)
			y = 1;
		if (y > gda_pkg::MaxYear)
			y = gda_pkg::MaxYear;
		if (m < 1)
			m = 1;
		if (m > 12)
			m = 12;
		left = left + w.days_ahead;
		while (!ovf && left > month_length(y, m)) begin
			left = left - month_length(y, m);
			m++;
			if (m > 12) begin
				m = 1;
				y++;
				if (y > gda_pkg::MaxYear)
					ovf = 1'b1;
			end
		end
		if (ovf) begin
			y    = gda_pkg::MaxYear;
			m    = gda_pkg::December;
			left = gda_pkg::LastDay;
		end
		r.end_year      = gda_pkg::YearW'(y);
		r.end_month     = gda_pkg::MonthW'(m);
		r.end_day       = gda_pkg::DayW'(left);
		r.year_overflow = ovf;
		return r;
	endfunction

	// mostly well-formed dates; some raw bit patterns; small counts when forced
	function automatic gda_pkg::in_word_t random_date(bit short_count);
		gda_pkg::in_word_t w;
		int unsigned       pick;
		pick          = $urandom_range(0, 99);
		w.start_year  = gda_pkg::YearW'($urandom_range(1, 9999));
		w.start_month = gda_pkg::MonthW'($urandom_range(1, 12));
		w.start_day   = gda_pkg::DayW'($urandom_range(1,
			month_length(w.start_year, w.start_month)));
		if (short_count)
			w.days_ahead = gda_pkg::CountW'($urandom_range(0, 40));
		else if (pick < 40)
			w.days_ahead = gda_pkg::CountW'($urandom_range(0, 400));
		else if (pick < 65)
			w.days_ahead = gda_pkg::CountW'($urandom_range(0, 5000));
		else if (pick < 80)
			w.days_ahead = gda_pkg::CountW'($urandom_range(0, 65535));
		else if (pick < 88) begin
			w.start_year = gda_pkg::YearW'($urandom_range(9800, 9999));
			w.days_ahead = gda_pkg::CountW'($urandom_range(0, 65535));
		end else begin
			w.start_year  = gda_pkg::YearW'($urandom);
			w.start_month = gda_pkg::MonthW'($urandom);
			w.start_day   = gda_pkg::DayW'($urandom);
			w.days_ahead  = gda_pkg::CountW'($urandom_range(0, 2000));
		end
		return w;
	endfunction

	task automatic send_date(gda_pkg::in_word_t w, gda_pkg::out_word_t want);
		if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= w;
		do
			@(posedge clk);
		while (!req_if.ready);
		pending_dates.push_back(want);
	endtask

	always #4 clk = ~clk;

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		req_if.valid <= 1'b0;
		req_if.data  <= '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#25_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: random stall bursts, one long hold-off to back up the block
	initial begin
		rsp_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				rsp_if.ready <= 1'b0;
				repeat (HoldLen) @(posedge clk);
				hold_done = 1'b1;
				rsp_if.ready <= 1'b1;
			end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				rsp_if.ready <= 1'b1;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		gda_pkg::out_word_t want;
		if (rsp_if.valid && rsp_if.ready) begin
			if (pending_dates.size() == 0) begin
				$error("unexpected result word: %p", rsp_if.data);
				mismatch_cnt++;
			end else begin
				want = pending_dates.pop_front();
				if (rsp_if.data.end_year !== want.end_year) begin
					$error("end_year: expected %0d, got %0d", want.end_year,
						rsp_if.data.end_year);
					mismatch_cnt++;
				end
				if (rsp_if.data.end_month !== want.end_month) begin
					$error("end_month: expected %0d, got %0d", want.end_month,
						rsp_if.data.end_month);
					mismatch_cnt++;
				end
				if (rsp_if.data.end_day !== want.end_day) begin
					$error("end_day: expected %0d, got %0d", want.end_day,
						rsp_if.data.end_day);
					mismatch_cnt++;
				end
				if (rsp_if.data.year_overflow !== want.year_overflow) begin
					$error("year_overflow: expected %0d, got %0d", want.year_overflow,
						rsp_if.data.year_overflow);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		gda_pkg::in_word_t w;
		bit                short_count;
		@(posedge arst_n);
		@(posedge clk);
		foreach (date_table[i])
			send_date(date_table[i].stim,
				date_table[i].typed ? date_table[i].want : advance_date(date_table[i].stim));
		for (int unsigned i = 0; i < RandWords; i++) begin
			if (i == HoldAt)
				hold_req = 1'b1;
			if (i >= RandWords - QuietWords)
				quiet_phase = 1'b1;
			short_count = hold_req && !hold_done;
			w = random_date(short_count);
			send_date(w, advance_date(w));
		end
		req_if.valid <= 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
